// ===== hdl/kitt_pkg.sv =====
// Shared types, codes and defaults for the keyed interval timer table.
package kitt_pkg;

  localparam int SLOT_COUNT_DEF = 24;
  localparam int OWNER_BITS_DEF = 16;

  localparam int TIME_W     = 64;
  localparam int OWNER_W    = 16;
  localparam int IN_DATA_W  = 208;
  localparam int OUT_DATA_W = 152;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_GET    = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT   = 2'd1;
  localparam logic [1:0] STAT_BAD_OWNER = 2'd2;

  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_ALARM = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_APPLY,
    ST_REPLY,
    ST_FLUSH
  } state_t;

  // Timing part of one slot record.
  typedef struct packed {
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] deadline;
  } slot_time_t;

endpackage

// ===== hdl/kitt_cell.sv =====
// One slot of the timer ring: holds a record and takes its neighbor's record on a shift.
module kitt_cell import kitt_pkg::*; #(
  parameter int KEY_W = OWNER_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  logic [KEY_W-1:0] owner_in,
  input  logic             armed_in,
  input  slot_time_t       time_in,
  output logic [KEY_W-1:0] owner,
  output logic             armed,
  output slot_time_t       slot_time
);

  always_ff @(posedge clk) begin
    if (rst) begin
      owner     <= '0;
      armed     <= 1'b0;
      slot_time <= '0;
    end else if (shift) begin
      owner     <= owner_in;
      armed     <= armed_in;
      slot_time <= time_in;
    end
  end

endmodule

// ===== hdl/keyed_interval_timer_table.sv =====
// Keyed interval timer table: a ring of SLOT_COUNT slot cells rotating past one head.
// With a nonzero owner, set, get and cancel make a search pass and an apply pass around the
// ring, then send the reply word; a tick makes one apply pass, then the final alarm, if any.
// One item at a time: the next is accepted once the current one is done and the block is idle.
// The ring rotates one slot past the head per cycle, but a tick holds it while an alarm waits.
// Reset (rst, synchronous, active high) frees every slot and empties the output register.
module keyed_interval_timer_table import kitt_pkg::*; #(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int OWNER_BITS = OWNER_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // owner_id[15:0], first_delay_ns[79:16], period_ns[143:80], now_ns[207:144]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // opcode[1:0]
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // status[1:0], alarm_owner[17:2], remaining_ns[81:18], reload_ns[145:82], zero pad
  output logic [OUT_DATA_W-1:0] m_tdata,
  // kind[0]
  output logic [0:0]            m_tuser,
  output logic                  m_tlast
);

  localparam int KEY_W = (OWNER_BITS < OWNER_W) ? OWNER_BITS : OWNER_W;
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // Ring wiring: cell k takes from cell k+1, the tail takes the head's write-back.
  logic [KEY_W-1:0] ring_owner [SLOT_COUNT];
  logic             ring_armed [SLOT_COUNT];
  slot_time_t       ring_time  [SLOT_COUNT];

  logic             shift;
  logic [KEY_W-1:0] wb_owner;
  logic             wb_armed;
  slot_time_t       wb_time;

  genvar k;
  generate
    for (k = 0; k < SLOT_COUNT; k++) begin : g_cell
      if (k == SLOT_COUNT - 1) begin : g_tail
        kitt_cell #(.KEY_W(KEY_W)) u_cell (
          .clk(clk), .rst(rst), .shift(shift),
          .owner_in(wb_owner), .armed_in(wb_armed), .time_in(wb_time),
          .owner(ring_owner[k]), .armed(ring_armed[k]), .slot_time(ring_time[k])
        );
      end else begin : g_mid
        kitt_cell #(.KEY_W(KEY_W)) u_cell (
          .clk(clk), .rst(rst), .shift(shift),
          .owner_in(ring_owner[k+1]), .armed_in(ring_armed[k+1]),
          .time_in(ring_time[k+1]),
          .owner(ring_owner[k]), .armed(ring_armed[k]), .slot_time(ring_time[k])
        );
      end
    end
  endgenerate

  logic [KEY_W-1:0] head_owner;
  logic             head_armed;
  slot_time_t       head_time;
  assign head_owner = ring_owner[0];
  assign head_armed = ring_armed[0];
  assign head_time  = ring_time[0];

  // Item registers.
  state_t            state, state_next;
  logic [IDX_W-1:0]  cnt;
  logic [1:0]        op;
  logic [KEY_W-1:0]  owner_key;
  logic [TIME_W-1:0] delay;
  logic [TIME_W-1:0] period;
  logic [TIME_W-1:0] now;
  logic              hit_found, free_found;
  logic [IDX_W-1:0]  hit_idx, free_idx;
  logic [TIME_W-1:0] rem, rel;
  logic [1:0]        reply_status;
  logic              pend_valid;
  logic [KEY_W-1:0]  pend_owner;

  logic [KEY_W-1:0]  in_key;
  assign in_key   = s_tdata[KEY_W-1:0];
  assign s_tready = (state == ST_IDLE);

  logic can_emit;
  assign can_emit = !m_tvalid || m_tready;

  // Target slot for set, get and cancel, decided after the search pass.
  logic             arm_req;
  logic             tgt_valid;
  logic [IDX_W-1:0] tgt_idx;
  logic             at_tgt;
  always_comb begin
    arm_req   = (op == OP_SET) && (delay != '0);
    tgt_valid = hit_found || (arm_req && free_found);
    tgt_idx   = hit_found ? hit_idx : free_idx;
    at_tgt    = tgt_valid && (cnt == tgt_idx);
  end

  // Per-slot arithmetic on the head cell.
  logic              expired;
  logic [TIME_W-1:0] step_dl, catch_dl, head_rem;
  logic              pend_after;
  always_comb begin
    expired    = head_armed && !(head_time.deadline > now);
    step_dl    = head_time.deadline + head_time.period;
    catch_dl   = now + head_time.period;
    head_rem   = (head_time.deadline > now) ? (head_time.deadline - now) : '0;
    pend_after = pend_valid || expired;
  end

  logic             push;
  logic             push_kind;
  logic [1:0]       push_status;
  logic [KEY_W-1:0] push_owner;
  logic             push_last;

  // Output and write-back decode.
  always_comb begin
    shift       = 1'b0;
    push        = 1'b0;
    push_kind   = KIND_REPLY;
    push_status = STAT_OK;
    push_owner  = '0;
    push_last   = 1'b1;
    wb_owner    = head_owner;
    wb_armed    = head_armed;
    wb_time     = head_time;
    unique case (state)
      ST_IDLE: begin
      end
      ST_SEARCH: begin
        shift = 1'b1;
      end
      ST_APPLY: begin
        if (op == OP_TICK) begin
          shift = !(expired && pend_valid && !can_emit);
          if (expired) begin
            if (head_time.period != '0) begin
              wb_time.deadline = (step_dl <= now) ? catch_dl : step_dl;
            end else begin
              wb_time.deadline = '0;
              wb_armed         = 1'b0;
            end
            // The previous alarm is known not to be the final one now.
            if (pend_valid && can_emit) begin
              push       = 1'b1;
              push_kind  = KIND_ALARM;
              push_owner = pend_owner;
              push_last  = 1'b0;
            end
          end
        end else begin
          shift = 1'b1;
          if (at_tgt) begin
            if (arm_req) begin
              wb_owner         = owner_key;
              wb_armed         = 1'b1;
              wb_time.period   = period;
              wb_time.deadline = now + delay;
            end else if (op != OP_GET) begin
              wb_owner = '0;
              wb_armed = 1'b0;
              wb_time  = '0;
            end
          end
        end
      end
      ST_REPLY: begin
        push        = can_emit;
        push_status = reply_status;
      end
      ST_FLUSH: begin
        push       = can_emit;
        push_kind  = KIND_ALARM;
        push_owner = pend_owner;
      end
      default: begin
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == OP_TICK) begin
            state_next = ST_APPLY;
          end else if (in_key == '0) begin
            state_next = ST_REPLY;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (cnt == LAST_IDX) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (shift && cnt == LAST_IDX) begin
          if (op != OP_TICK) begin
            state_next = ST_REPLY;
          end else if (pend_after) begin
            state_next = ST_FLUSH;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_REPLY, ST_FLUSH: begin
        if (can_emit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && s_tvalid) begin
        cnt          <= '0;
        hit_found    <= 1'b0;
        free_found   <= 1'b0;
        pend_valid   <= 1'b0;
        rem          <= '0;
        rel          <= '0;
        reply_status <= (s_tuser != OP_TICK && in_key == '0) ? STAT_BAD_OWNER : STAT_OK;
      end else if (shift) begin
        cnt <= (cnt == LAST_IDX) ? '0 : cnt + 1'b1;
      end
      if (state == ST_SEARCH) begin
        if (!hit_found && head_owner == owner_key) begin
          hit_found <= 1'b1;
          hit_idx   <= cnt;
        end
        if (!free_found && head_owner == '0) begin
          free_found <= 1'b1;
          free_idx   <= cnt;
        end
      end
      if (state == ST_APPLY && shift) begin
        if (op == OP_TICK && expired) begin
          pend_valid <= 1'b1;
          pend_owner <= head_owner;
        end
        if (op == OP_GET && at_tgt && head_armed) begin
          rem <= head_rem;
          rel <= head_time.period;
        end
        if (cnt == LAST_IDX && arm_req && !tgt_valid) begin
          reply_status <= STAT_NO_SLOT;
        end
      end
      if (state == ST_FLUSH && can_emit) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // Item payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      op        <= s_tuser;
      owner_key <= in_key;
      delay     <= s_tdata[79:16];
      period    <= s_tdata[143:80];
      now       <= s_tdata[207:144];
    end
  end

  // Output register: the ring keeps turning while a word waits unless a second one is due.
  logic              out_kind;
  logic [1:0]        out_status;
  logic [OWNER_W-1:0] out_owner;
  logic [TIME_W-1:0] out_rem, out_rel;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind   <= push_kind;
      out_status <= push_status;
      out_owner  <= OWNER_W'(push_owner);
      out_rem    <= (push_kind == KIND_REPLY) ? rem : '0;
      out_rel    <= (push_kind == KIND_REPLY) ? rel : '0;
      m_tlast    <= push_last;
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = {6'd0, out_rel, out_rem, out_owner, out_status};

`ifndef SYNTHESIS
  a_idle_cnt_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (cnt == '0))
    else $error("slot counter not at zero while idle");

  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (state == ST_APPLY || state == ST_FLUSH))
    else $error("pending alarm outside a tick");

  a_accept_path: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser != OP_TICK) |=>
      (state == ST_SEARCH || state == ST_REPLY))
    else $error("request did not start a search or a reply");

  a_reply_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0] == KIND_REPLY) |-> m_tlast)
    else $error("reply word without last");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the keyed interval timer table with a shadow timer table.
`timescale 1ns / 1ps

import kitt_pkg::*;

typedef struct packed {
  logic               kind;
  logic [1:0]         status;
  logic [OWNER_W-1:0] owner;
  logic [TIME_W-1:0]  remaining;
  logic [TIME_W-1:0]  reload;
  logic               last;
} timer_word_t;

class timer_shadow;
  logic [OWNER_W-1:0] slot_key    [SLOT_COUNT_DEF];
  logic [TIME_W-1:0]  slot_reload [SLOT_COUNT_DEF];
  logic [TIME_W-1:0]  slot_due    [SLOT_COUNT_DEF];
  bit                 slot_live   [SLOT_COUNT_DEF];
  timer_word_t        due_words[$];
  int                 fault_count;

  function new();
    for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
      vacate(i);
    end
    fault_count = 0;
  endfunction

  function void vacate(int i);
    slot_key[i]    = '0;
    slot_reload[i] = '0;
    slot_due[i]    = '0;
    slot_live[i]   = 1'b0;
  endfunction

  function void report(string msg);
    $display("tb: mismatch: %s", msg);
    fault_count++;
  endfunction

  function void push_reply(logic [1:0] status, logic [TIME_W-1:0] rem,
                           logic [TIME_W-1:0] rel);
    timer_word_t w;
    w = '0;
    w.kind = KIND_REPLY;
    w.status = status;
    w.remaining = rem;
    w.reload = rel;
    w.last = 1'b1;
    due_words.push_back(w);
  endfunction

  // Applies one accepted request word to the shadow table and queues its results.
  function void take_request(logic [1:0] op, logic [OWNER_W-1:0] owner,
                             logic [TIME_W-1:0] delay, logic [TIME_W-1:0] period,
                             logic [TIME_W-1:0] stamp);
    int idx;
    int start;
    timer_word_t w;
    logic [TIME_W-1:0] next;
    if (op == OP_TICK) begin
      start = due_words.size();
      for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
        if (slot_live[i] && slot_due[i] <= stamp) begin
          w = '0;
          w.kind = KIND_ALARM;
          w.status = STAT_OK;
          w.owner = slot_key[i];
          due_words.push_back(w);
          if (slot_reload[i] != '0) begin
            next = slot_due[i] + slot_reload[i];
            if (next <= stamp) next = stamp + slot_reload[i];
            slot_due[i] = next;
          end else begin
            slot_due[i] = '0;
            slot_live[i] = 1'b0;
          end
        end
      end
      if (due_words.size() > start) begin
        w = due_words.pop_back();
        w.last = 1'b1;
        due_words.push_back(w);
      end
    end else if (owner == '0) begin
      push_reply(STAT_BAD_OWNER, '0, '0);
    end else begin
      idx = -1;
      for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
        if (idx < 0 && slot_key[i] == owner) idx = i;
      end
      case (op)
        OP_SET: begin
          if (delay == '0) begin
            if (idx >= 0) vacate(idx);
            push_reply(STAT_OK, '0, '0);
          end else begin
            for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
              if (idx < 0 && slot_key[i] == '0) idx = i;
            end
            if (idx < 0) begin
              push_reply(STAT_NO_SLOT, '0, '0);
            end else begin
              slot_key[idx]    = owner;
              slot_reload[idx] = period;
              slot_due[idx]    = stamp + delay;
              slot_live[idx]   = 1'b1;
              push_reply(STAT_OK, '0, '0);
            end
          end
        end
        OP_GET: begin
          if (idx >= 0 && slot_live[idx])
            push_reply(STAT_OK, (slot_due[idx] > stamp) ? slot_due[idx] - stamp : '0,
                       slot_reload[idx]);
          else
            push_reply(STAT_OK, '0, '0);
        end
        default: begin
          if (idx >= 0) vacate(idx);
          push_reply(STAT_OK, '0, '0);
        end
      endcase
    end
  endfunction

  function void match_word(timer_word_t got);
    timer_word_t want;
    if (due_words.size() == 0) begin
      report($sformatf("unexpected word kind %0d owner %h", got.kind, got.owner));
      return;
    end
    want = due_words.pop_front();
    if (got.kind !== want.kind)
      report($sformatf("kind %0d, wanted %0d", got.kind, want.kind));
    if (got.status !== want.status)
      report($sformatf("status %0d, wanted %0d", got.status, want.status));
    if (got.owner !== want.owner)
      report($sformatf("alarm owner %h, wanted %h", got.owner, want.owner));
    if (got.remaining !== want.remaining)
      report($sformatf("remaining %h, wanted %h", got.remaining, want.remaining));
    if (got.reload !== want.reload)
      report($sformatf("reload %h, wanted %h", got.reload, want.reload));
    if (got.last !== want.last)
      report($sformatf("last %0d, wanted %0d", got.last, want.last));
  endfunction
endclass

module tb;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 335;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  m_tlast;

  timer_shadow       shadow;
  int                idle_cycles;
  int                stall_left;
  bit                calm;
  logic [TIME_W-1:0] now_ns;

  keyed_interval_timer_table uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Returns at the falling edge after the word is taken, with tvalid still high.
  task send_item(input logic [1:0] op, input logic [OWNER_W-1:0] owner,
                 input logic [TIME_W-1:0] delay, input logic [TIME_W-1:0] period,
                 input logic [TIME_W-1:0] stamp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {stamp, period, delay, owner};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task wait_drained();
    s_tvalid <= 1'b0;
    while (shadow.due_words.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      shadow.take_request(s_tuser, s_tdata[15:0], s_tdata[79:16], s_tdata[143:80],
                          s_tdata[207:144]);
    if (!rst && m_tvalid && m_tready)
      shadow.match_word(timer_word_t'({m_tuser[0], m_tdata[1:0], m_tdata[17:2],
                                       m_tdata[81:18], m_tdata[145:82], m_tlast}));
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("tb: done, errors");
    $finish;
  end

  // Result side: random stalls of mostly short and sometimes long length.
  initial begin
    m_tready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len();
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [OWNER_W-1:0] pool [32];
    logic [1:0]         op;
    logic [OWNER_W-1:0] owner;
    logic [TIME_W-1:0]  delay;
    logic [TIME_W-1:0]  period;
    logic [TIME_W-1:0]  stamp;
    int                 sent;
    int                 episode;
    int                 len;
    int                 psize;
    int                 r;

    shadow = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_SET;
    calm = 1'b0;
    idle_cycles = 0;
    now_ns = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Owner zero is refused by every keyed operation.
    send_item(OP_SET, 16'h0000, 64'd100, 64'd0, 64'd1000);
    send_item(OP_GET, 16'h0000, 64'd0, 64'd0, 64'd1000);
    send_item(OP_CANCEL, 16'h0000, 64'd0, 64'd0, 64'd1000);
    send_item(OP_GET, 16'h0005, 64'd0, 64'd0, 64'd1000);
    send_item(OP_CANCEL, 16'h0005, 64'd0, 64'd0, 64'd1000);
    send_item(OP_SET, 16'hFFFF, 64'd100, 64'd0, 64'd1000);
    send_item(OP_GET, 16'hFFFF, 64'd0, 64'd0, 64'd1050);
    // The first deadline wraps to just before now.
    send_item(OP_SET, 16'h0001, '1, '1, 64'd1000);
    send_item(OP_SET, 16'h0002, 64'd30, 64'd20, 64'd1000);
    send_item(OP_GET, 16'h0001, 64'd0, 64'd0, 64'd1000);
    send_item(OP_TICK, 16'hA5A5, '1, '0, 64'd1200);
    send_item(OP_GET, 16'hFFFF, 64'd0, 64'd0, 64'd1200);
    send_item(OP_TICK, 16'h0000, 64'd0, 64'd0, 64'd1225);
    send_item(OP_SET, 16'hFFFF, 64'd0, 64'd7, 64'd1225);
    send_item(OP_CANCEL, 16'h0002, 64'd0, 64'd0, 64'd1225);
    // The stepped deadline wraps to exactly zero and the slot stays armed.
    send_item(OP_SET, 16'h0004, 64'd500, 64'hFFFF_FFFF_FFFF_F63C, 64'd2000);
    send_item(OP_TICK, 16'h0004, 64'd0, 64'd0, 64'd2500);
    send_item(OP_GET, 16'h0004, 64'd0, 64'd0, 64'd2600);
    send_item(OP_CANCEL, 16'h0004, 64'd0, 64'd0, 64'd2600);
    send_item(OP_CANCEL, 16'h0001, 64'd0, 64'd0, 64'd2600);
    send_item(OP_TICK, 16'h1234, 64'd0, 64'd0, 64'd1500);
    send_item(OP_SET, 16'h0003, 64'd5, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(OP_SET, 16'h0007, 64'd10, 64'd1, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(OP_TICK, 16'hFFFF, '1, '1, '1);
    send_item(OP_GET, 16'h0007, 64'd0, 64'd0, 64'd5);
    wait_drained();

    now_ns = 64'd10000;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      episode = $urandom_range(0, 9);
      calm = ($urandom_range(0, 4) == 0);
      if (episode < 6) begin
        psize = 6;
        len = $urandom_range(20, 40);
      end else if (episode < 8) begin
        psize = 32;
        len = 40;
      end else begin
        psize = 1;
        len = 8;
      end
      for (int k = 0; k < 32; k++) begin
        pool[k] = OWNER_W'($urandom_range(1, 65535));
      end
      for (int n = 0; n < len && sent < RANDOM_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (episode >= 8) begin
          // Noise: every field fully random, time jumps anywhere.
          op = 2'($urandom_range(0, 3));
          owner = OWNER_W'($urandom_range(0, 65535));
          delay = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
          period = ($urandom_range(0, 9) == 0) ? '0 : {$urandom, $urandom};
          now_ns = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
        end else begin
          if (episode < 6) begin
            if (r < 40) op = OP_SET;
            else if (r < 60) op = OP_GET;
            else if (r < 70) op = OP_CANCEL;
            else op = OP_TICK;
          end else begin
            if (r < 70) op = OP_SET;
            else if (r < 82) op = OP_GET;
            else if (r < 87) op = OP_CANCEL;
            else op = OP_TICK;
          end
          owner = ($urandom_range(0, 99) < 3) ? '0 : pool[$urandom_range(0, psize - 1)];
          now_ns += TIME_W'($urandom_range(0, 120));
          if (op == OP_SET) begin
            delay = ($urandom_range(0, 99) < 8) ? '0
                    : TIME_W'($urandom_range(1, (episode < 6) ? 400 : 2000));
            period = ($urandom_range(0, 99) < 30) ? '0 : TIME_W'($urandom_range(1, 300));
          end else begin
            delay = {$urandom, $urandom};
            period = {$urandom, $urandom};
          end
        end
        stamp = now_ns;
        send_item(op, owner, delay, period, stamp);
        sent++;
      end
      if (episode >= 6 && episode < 8) begin
        // A late tick after a crowded phase expires most slots at once.
        now_ns += 3000;
        send_item(OP_TICK, OWNER_W'($urandom_range(0, 65535)), {$urandom, $urandom},
                  {$urandom, $urandom}, now_ns);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    calm = 1'b0;
    wait_drained();
    repeat (3 * SLOT_COUNT_DEF + 8) @(posedge clk);
    if (shadow.due_words.size() != 0)
      shadow.report($sformatf("%0d words never arrived", shadow.due_words.size()));
    if (shadow.fault_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end
endmodule
